@@ design/bbd_pkg.sv @@
`timescale 1ns / 1ps

package bbd_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int PIX_W = 8;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int FW_W = 11;
	localparam int FH_W = 12;
	localparam int ROW_W = FH_W;
	localparam int EW_W = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
	localparam int LINE_W = 2 * PIX_W;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 11'd160;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd120;

	localparam logic [EW_W-1:0] MIN_WIDTH = EW_W'(4);
	localparam logic [FH_W-1:0] MIN_HEIGHT = FH_W'(4);
	localparam logic [EW_W-1:0] MAX_WIDTH_EVEN = EW_W'(MAX_WIDTH - (MAX_WIDTH % 2));

	localparam logic [19:0] DIV3_MUL = 20'd683;
	localparam int DIV3_SHIFT = 11;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic [COL_W-1:0] px;
		logic [ROW_W-1:0] py;
		logic [EW_W-1:0] w;
		logic [FH_W-1:0] h;
		logic dr;
		logic dc;
	} pos_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic frame_end;
	} rgb_t;

endpackage

@@ design/bbd_ram.sv @@
`timescale 1ns / 1ps

module bbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/bbd_colour.sv @@
`timescale 1ns / 1ps

module bbd_colour (
	input  bbd_pkg::window_t win,
	input  bbd_pkg::pos_t    pos,
	output bbd_pkg::rgb_t    rgb
);

	function automatic bbd_pkg::pix_t avg2(input bbd_pkg::pix_t a, input bbd_pkg::pix_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic bbd_pkg::pix_t avg3(input bbd_pkg::pix_t a, input bbd_pkg::pix_t b,
			input bbd_pkg::pix_t c);
		logic [9:0] s;
		logic [19:0] p;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c};
		p = 20'(s) * bbd_pkg::DIV3_MUL;
		return p[bbd_pkg::DIV3_SHIFT +: 8];
	endfunction

	function automatic bbd_pkg::pix_t avg4(input bbd_pkg::pix_t a, input bbd_pkg::pix_t b,
			input bbd_pkg::pix_t c, input bbd_pkg::pix_t d);
		logic [9:0] s;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
		return s[9:2];
	endfunction

	bbd_pkg::pix_t grid [4][4];
	bbd_pkg::pix_t c, l, rt, u, d, ul, ur, dl, drt;
	logic top, bot, lft, rgt, xo, yo;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < 4; k++) begin
				if (r < 3 && k < 3) begin
					grid[r][k] = win[r][k];
				end else begin
					grid[r][k] = '0;
				end
			end
		end
	end

	always_comb begin
		c   = grid[{1'b0, pos.dr} + 2'd1][{1'b0, pos.dc} + 2'd1];
		l   = grid[{1'b0, pos.dr} + 2'd1][{1'b0, pos.dc}];
		rt  = grid[{1'b0, pos.dr} + 2'd1][{1'b0, pos.dc} + 2'd2];
		u   = grid[{1'b0, pos.dr}][{1'b0, pos.dc} + 2'd1];
		d   = grid[{1'b0, pos.dr} + 2'd2][{1'b0, pos.dc} + 2'd1];
		ul  = grid[{1'b0, pos.dr}][{1'b0, pos.dc}];
		ur  = grid[{1'b0, pos.dr}][{1'b0, pos.dc} + 2'd2];
		dl  = grid[{1'b0, pos.dr} + 2'd2][{1'b0, pos.dc}];
		drt = grid[{1'b0, pos.dr} + 2'd2][{1'b0, pos.dc} + 2'd2];
	end

	assign top = (pos.py == '0);
	assign bot = (pos.py == pos.h - bbd_pkg::FH_W'(1));
	assign lft = (pos.px == '0);
	assign rgt = (bbd_pkg::EW_W'(pos.px) == pos.w - bbd_pkg::EW_W'(1));
	assign xo = pos.px[0];
	assign yo = pos.py[0];

	always_comb begin
		rgb.frame_end = rgt && bot;
		if (top && lft) begin
			rgb.red = c; rgb.green = avg2(rt, d); rgb.blue = drt;
		end else if (bot && lft) begin
			rgb.red = u; rgb.green = c; rgb.blue = rt;
		end else if (top && rgt) begin
			rgb.red = l; rgb.green = c; rgb.blue = d;
		end else if (bot && rgt) begin
			rgb.red = ul; rgb.green = avg2(l, u); rgb.blue = c;
		end else if (top) begin
			if (!xo) begin
				rgb.red = c; rgb.green = avg3(l, rt, d); rgb.blue = avg2(dl, drt);
			end else begin
				rgb.red = avg2(l, rt); rgb.green = c; rgb.blue = d;
			end
		end else if (bot) begin
			if (xo) begin
				rgb.red = avg2(ul, ur); rgb.green = avg3(l, rt, u); rgb.blue = c;
			end else begin
				rgb.red = u; rgb.green = c; rgb.blue = avg2(l, rt);
			end
		end else if (lft) begin
			if (!yo) begin
				rgb.red = c; rgb.green = avg3(rt, u, d); rgb.blue = avg2(drt, ur);
			end else begin
				rgb.red = avg2(d, u); rgb.green = c; rgb.blue = rt;
			end
		end else if (rgt) begin
			if (yo) begin
				rgb.red = avg2(ul, dl); rgb.green = avg3(l, d, u); rgb.blue = c;
			end else begin
				rgb.red = l; rgb.green = c; rgb.blue = avg2(u, d);
			end
		end else if (!yo) begin
			if (!xo) begin
				rgb.red = c; rgb.green = avg4(rt, l, d, u); rgb.blue = avg4(drt, dl, ur, ul);
			end else begin
				rgb.red = avg2(rt, l); rgb.green = c; rgb.blue = avg2(d, u);
			end
		end else begin
			if (xo) begin
				rgb.red = avg4(drt, dl, ur, ul); rgb.green = avg4(rt, l, d, u); rgb.blue = c;
			end else begin
				rgb.red = avg2(d, u); rgb.green = c; rgb.blue = avg2(rt, l);
			end
		end
	end

endmodule

@@ design/bayer_rggb_bilinear_demosaic.sv @@
`timescale 1ns / 1ps

// RGGB bilinear demosaic, one raw pixel accepted per clock unless in_stall is high. The
// first result of a request passes the stage-1 register, the stage-2 window and the output
// register. Results leave one per cycle unless out_stall is high, from a single output
// register, so a request that yields two to four results (last row, right column) stalls
// the input until its last result loads, while row 0 and column 0 pass without a result.
// The two line stores share one 1024 x 16 RAM with one write and one registered read
// port; it needs no clearing after reset.
module bayer_rggb_bilinear_demosaic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bbd_pkg::PIX_W-1:0]         raw_pixel,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bbd_pkg::PIX_W-1:0]         red,
	output logic [bbd_pkg::PIX_W-1:0]         green,
	output logic [bbd_pkg::PIX_W-1:0]         blue,
	output logic                              run_last,
	output logic                              frame_end
);

	logic [bbd_pkg::FW_W-1:0] fw_q;
	logic [bbd_pkg::FH_W-1:0] fh_q;
	logic [bbd_pkg::EW_W-1:0] w_even, w_eff;
	logic [bbd_pkg::FH_W-1:0] h_even, h_eff;

	logic [bbd_pkg::COL_W-1:0] col_q, x;
	logic [bbd_pkg::ROW_W-1:0] row_q, y;
	logic [bbd_pkg::EW_W-1:0] nx;
	logic [bbd_pkg::ROW_W-1:0] ny;
	logic restart, in_acc;

	logic s1_v_q, s1_adv;
	bbd_pkg::pix_t s1_pix;
	logic [bbd_pkg::COL_W-1:0] s1_x;
	logic [bbd_pkg::ROW_W-1:0] s1_y;
	logic s1_emit, s1_last, s1_right, s1_fwd;
	logic [bbd_pkg::LINE_W-1:0] s1_fwd_data, s1_rd, ram_rdata;

	bbd_pkg::window_t win_s2;
	logic [bbd_pkg::COL_W-1:0] s2_x;
	logic [bbd_pkg::ROW_W-1:0] s2_y;
	logic [3:0] pend_q, sel, pend_next;
	logic s2_free, out_load;

	logic out_v_q;
	bbd_pkg::rgb_t rgb, rgb_q;
	logic run_last_q;
	bbd_pkg::pos_t pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bbd_pkg::FRAME_WIDTH_RST;
			fh_q <= bbd_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bbd_pkg::REG_FRAME_WIDTH: fw_q <= cfg_data[bbd_pkg::FW_W-1:0];
				bbd_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data[bbd_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_even = bbd_pkg::EW_W'({fw_q[bbd_pkg::FW_W-1:1], 1'b0});
		if (w_even < bbd_pkg::MIN_WIDTH) begin
			w_eff = bbd_pkg::MIN_WIDTH;
		end else if (w_even > bbd_pkg::MAX_WIDTH_EVEN) begin
			w_eff = bbd_pkg::MAX_WIDTH_EVEN;
		end else begin
			w_eff = w_even;
		end
		h_even = {fh_q[bbd_pkg::FH_W-1:1], 1'b0};
		h_eff = (h_even < bbd_pkg::MIN_HEIGHT) ? bbd_pkg::MIN_HEIGHT : h_even;
	end

	// position of the incoming pixel
	assign in_acc = in_valid && !in_stall;
	assign restart = frame_start || (bbd_pkg::EW_W'(col_q) >= w_eff) || (row_q >= h_eff);
	assign x = restart ? '0 : col_q;
	assign y = restart ? '0 : row_q;
	assign nx = bbd_pkg::EW_W'(x) + bbd_pkg::EW_W'(1);
	assign ny = y + bbd_pkg::ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (nx >= w_eff) begin
				col_q <= '0;
				row_q <= (ny >= h_eff) ? '0 : ny;
			end else begin
				col_q <= nx[bbd_pkg::COL_W-1:0];
				row_q <= y;
			end
		end
	end

	bbd_ram #(
		.WIDTH(bbd_pkg::LINE_W),
		.DEPTH(bbd_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk(clk),
		.we(s1_adv),
		.waddr(s1_x),
		.wdata({s1_rd[bbd_pkg::PIX_W-1:0], s1_pix}),
		.re(in_acc),
		.raddr(x),
		.rdata(ram_rdata)
	);

	// stage 1: line store read
	assign s1_rd = s1_fwd ? s1_fwd_data : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_pix <= raw_pixel;
			s1_x <= x;
			s1_y <= y;
			s1_emit <= (x != '0) && (y != '0);
			s1_last <= (y == h_eff - bbd_pkg::FH_W'(1));
			s1_right <= (bbd_pkg::EW_W'(x) == w_eff - bbd_pkg::EW_W'(1));
			s1_fwd <= s1_adv && (s1_x == x);
			s1_fwd_data <= {s1_rd[bbd_pkg::PIX_W-1:0], s1_pix};
		end
	end

	// stage 2: window and result sequencing
	assign sel = pend_q & (~pend_q + 4'd1);
	assign pend_next = pend_q & ~sel;
	assign out_load = (pend_q != '0) && (!out_v_q || !out_stall);
	assign s2_free = (pend_q == '0) || (out_load && (pend_next == '0));
	assign s1_adv = s1_v_q && s2_free;
	assign in_stall = s1_v_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			win_s2 <= '0;
		end else if (s1_adv) begin
			pend_q <= s1_emit ? {s1_last && s1_right, s1_right, s1_last, 1'b1} : 4'b0;
			for (int r = 0; r < 3; r++) begin
				win_s2[r][0] <= win_s2[r][1];
				win_s2[r][1] <= win_s2[r][2];
			end
			win_s2[0][2] <= s1_rd[bbd_pkg::LINE_W-1:bbd_pkg::PIX_W];
			win_s2[1][2] <= s1_rd[bbd_pkg::PIX_W-1:0];
			win_s2[2][2] <= s1_pix;
		end else if (out_load) begin
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_x <= s1_x;
			s2_y <= s1_y;
		end
	end

	always_comb begin
		pos.dr = sel[1] || sel[3];
		pos.dc = sel[2] || sel[3];
		pos.px = pos.dc ? s2_x : s2_x - bbd_pkg::COL_W'(1);
		pos.py = pos.dr ? s2_y : s2_y - bbd_pkg::ROW_W'(1);
		pos.w = w_eff;
		pos.h = h_eff;
	end

	bbd_colour u_colour (
		.win(win_s2),
		.pos(pos),
		.rgb(rgb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rgb_q <= rgb;
			run_last_q <= (pend_next == '0);
		end
	end

	assign out_valid = out_v_q;
	assign red = rgb_q.red;
	assign green = rgb_q.green;
	assign blue = rgb_q.blue;
	assign frame_end = rgb_q.frame_end;
	assign run_last = run_last_q;

endmodule

@@ test/bayer_rggb_bilinear_demosaic_test.sv @@
`timescale 1ns / 1ps

module bayer_rggb_bilinear_demosaic_test;

	localparam int SEND_IDLE_PCT = 37;
	localparam int RECV_IDLE_PCT = 85;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DIRECTED_ROWS = 25;
	localparam logic [bbd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bbd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		bbd_pkg::pix_t pix;
		logic fs;
		logic known;
		bbd_pkg::pix_t level;
	} pixel_req_t;

	typedef struct packed {
		bbd_pkg::pix_t red;
		bbd_pkg::pix_t green;
		bbd_pkg::pix_t blue;
		logic run_last;
		logic frame_end;
	} rgb_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bbd_pkg::pix_t raw_pixel = '0;
	logic frame_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	bbd_pkg::pix_t red;
	bbd_pkg::pix_t green;
	bbd_pkg::pix_t blue;
	logic run_last;
	logic frame_end;

	logic known_en = 1'b0;
	bbd_pkg::pix_t known_level = '0;

	int send_idle = 0;
	int recv_idle = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int mismatch_count = 0;

	rgb_result_t pending_rgb [$];

	bit [bbd_pkg::FW_W-1:0] cfg_width = bbd_pkg::FRAME_WIDTH_RST;
	bit [bbd_pkg::FH_W-1:0] cfg_height = bbd_pkg::FRAME_HEIGHT_RST;
	bit [bbd_pkg::PIX_W-1:0] upper_row [bbd_pkg::MAX_WIDTH];
	bit [bbd_pkg::PIX_W-1:0] middle_row [bbd_pkg::MAX_WIDTH];
	bit [bbd_pkg::PIX_W-1:0] win [3][3];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	pixel_req_t directed_reqs [DIRECTED_ROWS] = '{
		'{8'hFF, 1'b1, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'h00},
		'{8'h5A, 1'b1, 1'b0, 8'h00}
	};

	bayer_rggb_bilinear_demosaic dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_pixel(raw_pixel),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.run_last(run_last),
		.frame_end(frame_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned win_at(int wr, int wc);
		if (wr < 0 || wr > 2 || wc < 0 || wc > 2)
			return 0;
		return win[wr][wc];
	endfunction

	function automatic int unsigned active_width();
		int unsigned w;
		w = cfg_width & 11'h7FE;
		if (w < 4)
			w = 4;
		if (w > bbd_pkg::MAX_WIDTH_EVEN)
			w = bbd_pkg::MAX_WIDTH_EVEN;
		return w;
	endfunction

	function automatic int unsigned active_height();
		int unsigned h;
		h = cfg_height & 12'hFFE;
		if (h < 4)
			h = 4;
		return h;
	endfunction

	function automatic rgb_result_t shade(int unsigned px, int unsigned py, int dr, int dc,
			int unsigned w, int unsigned h);
		int unsigned c, l, rt, u, d, ul, ur, dl, drt, r, g, b;
		bit top, bot, lft, rgt, xo, yo;
		rgb_result_t res;
		c = win_at(1 + dr, 1 + dc);
		l = win_at(1 + dr, dc);
		rt = win_at(1 + dr, 2 + dc);
		u = win_at(dr, 1 + dc);
		d = win_at(2 + dr, 1 + dc);
		ul = win_at(dr, dc);
		ur = win_at(dr, 2 + dc);
		dl = win_at(2 + dr, dc);
		drt = win_at(2 + dr, 2 + dc);
		top = (py == 0);
		bot = (py == h - 1);
		lft = (px == 0);
		rgt = (px == w - 1);
		xo = px[0];
		yo = py[0];
		if (top && lft) begin
			r = c; g = (rt + d) / 2; b = drt;
		end else if (bot && lft) begin
			r = u; g = c; b = rt;
		end else if (top && rgt) begin
			r = l; g = c; b = d;
		end else if (bot && rgt) begin
			r = ul; g = (l + u) / 2; b = c;
		end else if (top) begin
			if (!xo) begin
				r = c; g = (l + rt + d) / 3; b = (dl + drt) / 2;
			end else begin
				r = (l + rt) / 2; g = c; b = d;
			end
		end else if (bot) begin
			if (xo) begin
				r = (ul + ur) / 2; g = (l + rt + u) / 3; b = c;
			end else begin
				r = u; g = c; b = (l + rt) / 2;
			end
		end else if (lft) begin
			if (!yo) begin
				r = c; g = (rt + u + d) / 3; b = (drt + ur) / 2;
			end else begin
				r = (d + u) / 2; g = c; b = rt;
			end
		end else if (rgt) begin
			if (yo) begin
				r = (ul + dl) / 2; g = (l + d + u) / 3; b = c;
			end else begin
				r = l; g = c; b = (u + d) / 2;
			end
		end else if (!yo) begin
			if (!xo) begin
				r = c; g = (rt + l + d + u) / 4; b = (drt + dl + ur + ul) / 4;
			end else begin
				r = (rt + l) / 2; g = c; b = (d + u) / 2;
			end
		end else begin
			if (xo) begin
				r = (drt + dl + ur + ul) / 4; g = (rt + l + d + u) / 4; b = c;
			end else begin
				r = (d + u) / 2; g = c; b = (rt + l) / 2;
			end
		end
		res.red = r[7:0];
		res.green = g[7:0];
		res.blue = b[7:0];
		res.run_last = 1'b0;
		res.frame_end = rgt && bot;
		return res;
	endfunction

	function automatic void demosaic_step(bbd_pkg::pix_t pix, logic fs, logic known,
			bbd_pkg::pix_t level);
		int unsigned w, h, x, y;
		rgb_result_t res [4];
		int n;
		bit last_row;
		w = active_width();
		h = active_height();
		n = 0;
		if (fs || col_pos >= w || row_pos >= h) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = col_pos;
		y = row_pos;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = upper_row[x];
		win[1][2] = middle_row[x];
		win[2][2] = pix;
		upper_row[x] = middle_row[x];
		middle_row[x] = pix;
		if (x >= 1 && y >= 1) begin
			last_row = (y == h - 1);
			res[n] = shade(x - 1, y - 1, 0, 0, w, h);
			n = n + 1;
			if (last_row) begin
				res[n] = shade(x - 1, y, 1, 0, w, h);
				n = n + 1;
			end
			if (x == w - 1) begin
				res[n] = shade(x, y - 1, 0, 1, w, h);
				n = n + 1;
				if (last_row) begin
					res[n] = shade(x, y, 1, 1, w, h);
					n = n + 1;
				end
			end
			res[n - 1].run_last = 1'b1;
		end
		for (int k = 0; k < n; k++) begin
			if (known) begin
				res[k].red = level;
				res[k].green = level;
				res[k].blue = level;
			end
			pending_rgb.push_back(res[k]);
		end
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	always @(posedge clk) begin : monitor
		rgb_result_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bbd_pkg::REG_FRAME_WIDTH)
					cfg_width = cfg_data[bbd_pkg::FW_W-1:0];
				else if (cfg_index == bbd_pkg::REG_FRAME_HEIGHT)
					cfg_height = cfg_data[bbd_pkg::FH_W-1:0];
			end
			if (in_valid && !in_stall)
				demosaic_step(raw_pixel, frame_start, known_en, known_level);
			if (out_valid && !out_stall) begin
				got = {red, green, blue, run_last, frame_end};
				if (pending_rgb.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b end=%0b",
						$time, red, green, blue, run_last, frame_end);
				end else begin
					want = pending_rgb.pop_front();
					if (got !== want) begin
						mismatch_count++;
						$display({"%0t: expected r=%0d g=%0d b=%0d last=%0b end=%0b,",
							" got r=%0d g=%0d b=%0d last=%0b end=%0b"},
							$time, want.red, want.green, want.blue, want.run_last,
							want.frame_end, red, green, blue, run_last, frame_end);
					end
				end
			end
		end
	end

	// hold off the output for a long stretch on request, else stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("bayer_rggb_bilinear_demosaic_test: FAIL");
		$finish;
	end

	task automatic write_reg(input logic [bbd_pkg::CFG_IDX_W-1:0] idx,
			input logic [bbd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input pixel_req_t req);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pixel <= req.pix;
		frame_start <= req.fs;
		known_en <= req.known;
		known_level <= req.level;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_rgb.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [bbd_pkg::CFG_DATA_W-1:0] width_val,
			input logic [bbd_pkg::CFG_DATA_W-1:0] height_val, input int count,
			input logic fs_first, input logic pressure);
		pixel_req_t req;
		write_reg(bbd_pkg::REG_FRAME_WIDTH, width_val);
		write_reg(bbd_pkg::REG_FRAME_HEIGHT, height_val);
		if (pressure)
			hold_request = 1'b1;
		for (int i = 0; i < count; i++) begin
			req.fs = (i == 0) ? fs_first : ($urandom_range(99) < 2);
			case ($urandom_range(9))
				0: req.pix = 8'h00;
				1: req.pix = 8'hFF;
				default: req.pix = bbd_pkg::PIX_W'($urandom_range(255));
			endcase
			req.known = 1'b0;
			req.level = '0;
			send_pixel(req);
		end
		drain_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = SEND_IDLE_PCT;
		recv_idle = RECV_IDLE_PCT;
		write_reg(bbd_pkg::REG_FRAME_WIDTH, 12'd0);
		write_reg(bbd_pkg::REG_FRAME_HEIGHT, 12'd3);
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_pixel(directed_reqs[i]);
		drain_results();
		run_phase(12'd4, 12'd4, 40, 1'b0, 1'b0);
		run_phase(12'd7, 12'd5, 30, 1'b1, 1'b0);
		send_idle = RECV_IDLE_PCT;
		recv_idle = SEND_IDLE_PCT;
		run_phase(12'd2047, 12'd4, 30, 1'b1, 1'b0);
		run_phase(12'd10, 12'd8, 30, 1'b0, 1'b0);
		send_idle = 0;
		recv_idle = 0;
		run_phase(12'h80C, 12'd4095, 30, 1'b1, 1'b1);
		write_reg(REG_SPARE_2, bbd_pkg::CFG_DATA_W'($urandom_range(4095)));
		write_reg(REG_SPARE_3, bbd_pkg::CFG_DATA_W'($urandom_range(4095)));
		run_phase(12'd6, 12'd6, 20, 1'($urandom_range(1)), 1'b0);
		if (mismatch_count == 0 && pending_rgb.size() == 0)
			$display("bayer_rggb_bilinear_demosaic_test: PASS");
		else
			$display("bayer_rggb_bilinear_demosaic_test: FAIL");
		$finish;
	end

endmodule

@@ bayer_rggb_bilinear_demosaic.f @@
design/bbd_pkg.sv
design/bbd_ram.sv
design/bbd_colour.sv
design/bayer_rggb_bilinear_demosaic.sv
test/bayer_rggb_bilinear_demosaic_test.sv
